@@ hdl/bpir_pkg.sv @@
// ----------------------------------------------------------------------------
// bpir_pkg: shared types and constants for the biphase IR frame decoder
// Status codes, register indexes, reset values and the frame state record.
// ----------------------------------------------------------------------------
`default_nettype none

package bpir_pkg;

    localparam int FRAME_BITS = 23;
    localparam int HALF_MAX   = 2 * FRAME_BITS;
    localparam int CNT_W      = 6;
    localparam int DUR_W      = 16;
    localparam int TICK_W     = 10;
    localparam int US_W       = 16;
    localparam int PROD_W     = DUR_W + TICK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_US      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_US     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_US      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_US = 2'd3;

    localparam logic [TICK_W-1:0] RST_TICK_US      = 10'd50;
    localparam logic [US_W-1:0]   RST_SHORT_US     = 16'd250;
    localparam logic [US_W-1:0]   RST_LONG_US      = 16'd500;
    localparam logic [US_W-1:0]   RST_TOLERANCE_US = 16'd50;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_LONG  = 3'd2,
        ST_FIRST = 3'd3,
        ST_PAIR  = 3'd4,
        ST_LEN   = 3'd5
    } t_status;

    typedef struct packed {
        logic [HALF_MAX-1:0] bits;
        logic [CNT_W-1:0]    cnt;
        t_status             err;
    } t_frame;

endpackage

`default_nettype wire

@@ hdl/biphase_ir_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// biphase_ir_frame_decoder: 23-bit biphase IR frame decoder
// Classifies pulse durations, collects half-bits and decodes one frame per
// word flagged with tlast into status and frame fields.
// ----------------------------------------------------------------------------
// Channel | Dir | Width | Contents (lowest bit first)
// s       | in  | 16+1  | tdata: duration_ticks[15:0]; tlast: last_item
// m       | out | 32    | tdata: status, start_bit, cust_code, battery_bit,
//         |     |       |        dev_code, address, repeat_flag, cmd_code
// cfg     | in  | 2+16  | index 0 tick_us, 1 short_us, 2 long_us, 3 tolerance_us
//
// One word accepted per cycle unless a last word is held for the output;
// a frame result passes the input register and the tick scaling multiplier
// register, then is classified into the result register.
// Synchronous active-low reset restores the register defaults and clears the
// frame; no clearing pass. Words without tlast keep flowing while a result
// waits on the output; a last word waits in the classify stage until the
// output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module biphase_ir_frame_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [15:0] duration_ticks
    input  wire logic [bpir_pkg::DUR_W-1:0]       i_s_tdata,
    input  wire logic                             i_s_tlast,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [2:0] status, [3] start_bit, [9:4] cust_code, [10] battery_bit,
    // [13:11] dev_code, [16:14] address, [17] repeat_flag,
    // [25:18] cmd_code, [31:26] zero
    output logic [bpir_pkg::OUT_W-1:0]            o_m_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [bpir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bpir_pkg::US_W-1:0]        i_cfg_data
);

    localparam int HM = bpir_pkg::HALF_MAX;
    localparam int PW = bpir_pkg::PROD_W;

    logic [bpir_pkg::TICK_W-1:0] r_tick_us;
    logic [bpir_pkg::US_W-1:0]   r_short_us;
    logic [bpir_pkg::US_W-1:0]   r_long_us;
    logic [bpir_pkg::US_W-1:0]   r_tol_us;

    logic                        r_a_valid;
    logic [bpir_pkg::DUR_W-1:0]  r_a_ticks;
    logic                        r_a_last;
    logic                        r_b_valid;
    logic [PW-1:0]               r_b_prod;
    logic                        r_b_last;

    logic [HM-1:0]               r_half_bits;
    logic [bpir_pkg::CNT_W-1:0]  r_half_count;
    logic [15:0]                 r_item_index;
    bpir_pkg::t_status           r_err;

    logic                        r_o_valid;
    logic [bpir_pkg::OUT_W-1:0]  r_o_data;

    logic                        out_free;
    logic                        b_go;
    logic                        b_ready;
    logic                        a_ready;

    logic [bpir_pkg::US_W-1:0]   lo_s;
    logic [bpir_pkg::US_W-1:0]   lo_l;
    logic [bpir_pkg::US_W:0]     hi_s;
    logic [bpir_pkg::US_W:0]     hi_l;
    logic                        mark;
    bpir_pkg::t_frame            fr_cur;
    bpir_pkg::t_frame            fr_upd;
    bpir_pkg::t_status           status;
    logic [bpir_pkg::FRAME_BITS-1:0] fbits;
    logic [5:0]                  cid;
    logic [2:0]                  dev;
    logic [2:0]                  adr;
    logic [7:0]                  fn;
    logic                        pair_bad;
    logic [bpir_pkg::OUT_W-1:0]  n_o_data;

    function automatic bpir_pkg::t_frame push_half(bpir_pkg::t_frame s, logic b);
        bpir_pkg::t_frame r;
        r = s;
        if (s.cnt < bpir_pkg::CNT_W'(HM)) begin
            if (b) begin
                r.bits[s.cnt] = 1'b1;
            end
            r.cnt = s.cnt + 1'b1;
        end else begin
            r.cnt = bpir_pkg::CNT_W'(HM + 1);
            if (s.err == bpir_pkg::ST_OK) begin
                r.err = bpir_pkg::ST_LEN;
            end
        end
        return r;
    endfunction

    assign out_free   = !r_o_valid || i_m_tready;
    assign b_go       = r_b_valid && (!r_b_last || out_free);
    assign b_ready    = !r_b_valid || b_go;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_s_tready = a_ready;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_us  <= bpir_pkg::RST_TICK_US;
            r_short_us <= bpir_pkg::RST_SHORT_US;
            r_long_us  <= bpir_pkg::RST_LONG_US;
            r_tol_us   <= bpir_pkg::RST_TOLERANCE_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpir_pkg::CFG_TICK_US:      r_tick_us  <= i_cfg_data[bpir_pkg::TICK_W-1:0];
                bpir_pkg::CFG_SHORT_US:     r_short_us <= i_cfg_data;
                bpir_pkg::CFG_LONG_US:      r_long_us  <= i_cfg_data;
                bpir_pkg::CFG_TOLERANCE_US: r_tol_us   <= i_cfg_data;
            endcase
        end
    end

    // input and scaling stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_s_tvalid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_ticks <= i_s_tdata;
            r_a_last  <= i_s_tlast;
        end
        if (b_ready) begin
            r_b_prod <= {{bpir_pkg::TICK_W{1'b0}}, r_a_ticks}
                      * {{bpir_pkg::DUR_W{1'b0}}, r_tick_us};
            r_b_last <= r_a_last;
        end
    end

    always_comb begin
        lo_s = (r_short_us > r_tol_us) ? r_short_us - r_tol_us : '0;
        lo_l = (r_long_us > r_tol_us) ? r_long_us - r_tol_us : '0;
        hi_s = {1'b0, r_short_us} + {1'b0, r_tol_us};
        hi_l = {1'b0, r_long_us} + {1'b0, r_tol_us};
        mark = ~r_item_index[0];

        fr_cur = '{bits: r_half_bits, cnt: r_half_count, err: r_err};
        fr_upd = fr_cur;
        if (r_err == bpir_pkg::ST_OK && r_b_prod != '0) begin
            if (r_b_prod < PW'(lo_s)) begin
                fr_upd.err = bpir_pkg::ST_SHORT;
            end else if (r_b_prod > PW'(hi_l)) begin
                fr_upd.err = bpir_pkg::ST_LONG;
            end else if (r_item_index == '0 && r_b_prod > PW'(hi_s)) begin
                fr_upd.err = bpir_pkg::ST_FIRST;
            end else begin
                fr_upd = push_half(fr_cur, mark);
                if (r_b_prod >= PW'(lo_l)) begin
                    fr_upd = push_half(fr_upd, mark);
                end
            end
        end

        pair_bad = 1'b0;
        for (int j = 0; j < bpir_pkg::FRAME_BITS; j++) begin
            fbits[j] = fr_upd.bits[2*j];
            if (fr_upd.bits[2*j] == fr_upd.bits[2*j+1]) begin
                pair_bad = 1'b1;
            end
        end

        status = fr_upd.err;
        if (status == bpir_pkg::ST_OK) begin
            if (fr_upd.cnt != bpir_pkg::CNT_W'(HM - 1)
                    && fr_upd.cnt != bpir_pkg::CNT_W'(HM)) begin
                status = bpir_pkg::ST_LEN;
            end else if (pair_bad) begin
                status = bpir_pkg::ST_PAIR;
            end
        end

        for (int j = 1; j <= 6; j++) begin
            cid[6-j] = fbits[j];
        end
        for (int j = 8; j <= 10; j++) begin
            dev[10-j] = fbits[j];
        end
        for (int j = 11; j <= 13; j++) begin
            adr[13-j] = fbits[j];
        end
        for (int j = 15; j <= 22; j++) begin
            fn[22-j] = fbits[j];
        end

        n_o_data = '0;
        n_o_data[2:0] = status;
        if (status == bpir_pkg::ST_OK) begin
            n_o_data[3]     = fbits[0];
            n_o_data[9:4]   = cid;
            n_o_data[10]    = fbits[7];
            n_o_data[13:11] = dev;
            n_o_data[16:14] = adr;
            n_o_data[17]    = fbits[14];
            n_o_data[25:18] = fn;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bits  <= '0;
            r_half_count <= '0;
            r_item_index <= '0;
            r_err        <= bpir_pkg::ST_OK;
        end else if (b_go) begin
            if (r_b_last) begin
                r_half_bits  <= '0;
                r_half_count <= '0;
                r_item_index <= '0;
                r_err        <= bpir_pkg::ST_OK;
            end else begin
                r_half_bits  <= fr_upd.bits;
                r_half_count <= fr_upd.cnt;
                r_item_index <= r_item_index + 1'b1;
                r_err        <= fr_upd.err;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_go && r_b_last) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && r_b_last) begin
            r_o_data <= n_o_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half_count <= bpir_pkg::CNT_W'(HM + 1))
        else $error("half-bit count beyond saturation");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_data[2:0] != bpir_pkg::ST_OK |-> r_o_data[31:3] == '0)
        else $error("error result carries frame fields");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_go && r_b_last |=> r_item_index == '0 && r_half_count == '0
            && r_err == bpir_pkg::ST_OK)
        else $error("frame state not cleared after last word");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != bpir_pkg::ST_OK && !(b_go && r_b_last) |=> r_err == $past(r_err))
        else $error("first error code overwritten");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !i_m_tready |-> !(b_go && r_b_last))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/biphase_ir_frame_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biphase_ir_frame_decoder_tb: self-checking bench for the biphase IR decoder
// Streams pulse durations into the decoder and predicts every frame word with
// an in-bench decoder. Each output word is compared field by field. A table
// of directed words and frames covers window edges and error codes. Random
// phases follow under several timing settings, with random idling on both
// stream sides except in the quiet first phase.
// ----------------------------------------------------------------------------
module biphase_ir_frame_decoder_tb;

    typedef struct packed {
        logic [5:0]        pad;
        logic [7:0]        cmd_code;
        logic              repeat_flag;
        logic [2:0]        address;
        logic [2:0]        dev_code;
        logic              battery_bit;
        logic [5:0]        cust_code;
        logic              start_bit;
        bpir_pkg::t_status status;
    } t_ir_frame;

    typedef enum logic {ROW_WORD, ROW_FRAME} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [22:0]       pat;
        logic              trim;
        logic [15:0]       ticks;
        logic              last;
        logic [16:0]       reps;
        logic              typed;
        bpir_pkg::t_status st;
    } t_row;

    localparam t_row DIR_TAB [20] = '{
        '{ROW_WORD,  23'h000000, 1'b0, 16'd3,     1'b1, 17'd1,  1'b1, bpir_pkg::ST_SHORT},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd12,    1'b1, 17'd1,  1'b1, bpir_pkg::ST_LONG},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd10,    1'b1, 17'd1,  1'b1, bpir_pkg::ST_FIRST},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd65535, 1'b1, 17'd1,  1'b1, bpir_pkg::ST_LONG},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd1,     1'b1, 17'd1,  1'b1, bpir_pkg::ST_SHORT},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd0,     1'b1, 17'd1,  1'b1, bpir_pkg::ST_LEN},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd5,     1'b1, 17'd1,  1'b1, bpir_pkg::ST_LEN},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd5,     1'b0, 17'd2,  1'b0, bpir_pkg::ST_OK},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd10,    1'b0, 17'd21, 1'b0, bpir_pkg::ST_OK},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd10,    1'b1, 17'd1,  1'b1, bpir_pkg::ST_PAIR},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd5,     1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd10,    1'b0, 17'd24, 1'b0, bpir_pkg::ST_OK},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd10,    1'b1, 17'd1,  1'b1, bpir_pkg::ST_LEN},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd3,     1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd12,    1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK},
        '{ROW_WORD,  23'h000000, 1'b0, 16'd10,    1'b1, 17'd1,  1'b1, bpir_pkg::ST_SHORT},
        '{ROW_FRAME, 23'h7FFFFF, 1'b1, 16'd0,     1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK},
        '{ROW_FRAME, 23'h000000, 1'b0, 16'd0,     1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK},
        '{ROW_FRAME, 23'h555555, 1'b1, 16'd0,     1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK},
        '{ROW_FRAME, 23'h2AAAAA, 1'b0, 16'd0,     1'b0, 17'd1,  1'b0, bpir_pkg::ST_OK}
    };

    logic                           clk;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bpir_pkg::DUR_W-1:0]     s_tdata  = '0;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bpir_pkg::OUT_W-1:0]     m_tdata;
    logic                           cfg_we   = 1'b0;
    logic [bpir_pkg::CFG_IDX_W-1:0] cfg_idx  = bpir_pkg::CFG_TICK_US;
    logic [bpir_pkg::US_W-1:0]      cfg_data = '0;

    logic [bpir_pkg::HALF_MAX-1:0]  half_bits = '0;
    logic [bpir_pkg::CNT_W-1:0]     half_cnt  = '0;
    logic [15:0]                    pulse_idx = '0;
    bpir_pkg::t_status              frame_err = bpir_pkg::ST_OK;
    int unsigned                    tick_us   = bpir_pkg::RST_TICK_US;
    int unsigned                    short_us  = bpir_pkg::RST_SHORT_US;
    int unsigned                    long_us   = bpir_pkg::RST_LONG_US;
    int unsigned                    tol_us    = bpir_pkg::RST_TOLERANCE_US;

    t_ir_frame                      decoded_q[$];
    int                             word_cnt  = 0;
    int                             bad_cnt   = 0;
    bit                             calm      = 1'b0;

    biphase_ir_frame_decoder u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned window_low(input int unsigned nominal);
        return (nominal > tol_us) ? nominal - tol_us : 0;
    endfunction

    function automatic void push_half(input logic b);
        if (half_cnt < bpir_pkg::HALF_MAX) begin
            half_bits[half_cnt] = b;
            half_cnt = half_cnt + 1'b1;
        end else begin
            half_cnt = bpir_pkg::CNT_W'(bpir_pkg::HALF_MAX + 1);
            if (frame_err == bpir_pkg::ST_OK)
                frame_err = bpir_pkg::ST_LEN;
        end
    endfunction

    function automatic bit decode_pulse(input logic [15:0] ticks, input logic last,
                                        output t_ir_frame res);
        int unsigned       us;
        logic [15:0]       pos;
        logic [22:0]       fb;
        bpir_pkg::t_status st;
        res = '0;
        fb  = '0;
        pos = pulse_idx;
        us  = ticks * tick_us;
        pulse_idx = pos + 16'd1;
        if (frame_err == bpir_pkg::ST_OK && us != 0) begin
            if (us < window_low(short_us))
                frame_err = bpir_pkg::ST_SHORT;
            else if (us > long_us + tol_us)
                frame_err = bpir_pkg::ST_LONG;
            else if (pos == 0 && us > short_us + tol_us)
                frame_err = bpir_pkg::ST_FIRST;
            else begin
                push_half(~pos[0]);
                if (us >= window_low(long_us))
                    push_half(~pos[0]);
            end
        end
        if (!last)
            return 1'b0;
        st = frame_err;
        if (st == bpir_pkg::ST_OK && half_cnt != bpir_pkg::HALF_MAX - 1
                && half_cnt != bpir_pkg::HALF_MAX)
            st = bpir_pkg::ST_LEN;
        for (int j = 0; j < bpir_pkg::FRAME_BITS; j++) begin
            if (st == bpir_pkg::ST_OK && half_bits[2*j] == half_bits[2*j+1])
                st = bpir_pkg::ST_PAIR;
            fb[j] = half_bits[2*j];
        end
        if (st == bpir_pkg::ST_OK) begin
            res.start_bit   = fb[0];
            res.cust_code   = {fb[1], fb[2], fb[3], fb[4], fb[5], fb[6]};
            res.battery_bit = fb[7];
            res.dev_code    = {fb[8], fb[9], fb[10]};
            res.address     = {fb[11], fb[12], fb[13]};
            res.repeat_flag = fb[14];
            res.cmd_code    = {fb[15], fb[16], fb[17], fb[18],
                               fb[19], fb[20], fb[21], fb[22]};
        end
        res.status = st;
        half_bits = '0;
        half_cnt  = '0;
        pulse_idx = '0;
        frame_err = bpir_pkg::ST_OK;
        return 1'b1;
    endfunction

    // pick a duration inside the short or long window at the current timing
    function automatic logic [15:0] pulse_ticks(input bit dbl);
        int unsigned lo;
        int unsigned hi;
        int unsigned t_lo;
        int unsigned t_hi;
        if (dbl) begin
            lo = window_low(long_us);
            hi = long_us + tol_us;
        end else begin
            lo = window_low(short_us);
            hi = short_us + tol_us;
            if (window_low(long_us) > 0 && window_low(long_us) - 1 < hi)
                hi = window_low(long_us) - 1;
        end
        if (lo == 0)
            lo = 1;
        t_lo = (lo + tick_us - 1) / tick_us;
        t_hi = hi / tick_us;
        if (t_hi > 65535)
            t_hi = 65535;
        if (t_lo > t_hi)
            return 16'((dbl ? long_us : short_us) / tick_us + 1);
        return 16'($urandom_range(t_hi, t_lo));
    endfunction

    function automatic void check_field(input string name, input logic [7:0] got,
                                        input logic [7:0] want);
        if (got !== want) begin
            bad_cnt++;
            if (bad_cnt <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(negedge clk) begin
        m_tready <= calm || ($urandom_range(99, 0) >= 9);
    end

    always @(posedge clk) begin : result_check
        t_ir_frame got;
        t_ir_frame want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_ir_frame'(m_tdata);
            if (decoded_q.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                want = decoded_q.pop_front();
                check_field("status", got.status, want.status);
                check_field("start_bit", got.start_bit, want.start_bit);
                check_field("cust_code", got.cust_code, want.cust_code);
                check_field("battery_bit", got.battery_bit, want.battery_bit);
                check_field("dev_code", got.dev_code, want.dev_code);
                check_field("address", got.address, want.address);
                check_field("repeat_flag", got.repeat_flag, want.repeat_flag);
                check_field("cmd_code", got.cmd_code, want.cmd_code);
            end
        end
    end

    task automatic send_word(input logic [15:0] ticks, input logic last, input logic typed,
                             input bpir_pkg::t_status st);
        t_ir_frame res;
        @(negedge clk);
        while (!calm && $urandom_range(99, 0) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ticks;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        word_cnt++;
        if (decode_pulse(ticks, last, res)) begin
            if (typed) begin
                res        = '0;
                res.status = st;
            end
            decoded_q.push_back(res);
        end
    endtask

    // encode a 23-bit frame as alternating mark/space durations
    task automatic send_frame(input logic [22:0] pat, input bit trim, input bit mutate);
        logic [45:0] hb;
        logic [15:0] t;
        int n;
        int p;
        int r;
        int k;
        int hit;
        for (int j = 0; j < bpir_pkg::FRAME_BITS; j++) begin
            hb[2*j]   = pat[j];
            hb[2*j+1] = ~pat[j];
        end
        n   = (trim && !hb[45]) ? 45 : 46;
        hit = mutate ? int'($urandom_range(30, 0)) : -1;
        p   = 0;
        k   = 0;
        if (!hb[0])
            send_word(16'd0, 1'b0, 1'b0, bpir_pkg::ST_OK);
        while (p < n) begin
            r = (p + 1 < n && hb[p+1] == hb[p]) ? 2 : 1;
            t = pulse_ticks(r == 2);
            if (k == hit)
                t = $urandom_range(1, 0) ? 16'($urandom_range(65535, 0)) : 16'(t * 2);
            p += r;
            k++;
            send_word(t, p >= n, 1'b0, bpir_pkg::ST_OK);
        end
    endtask

    task automatic send_noise();
        logic [15:0] t;
        int len;
        len = $urandom_range(40, 1);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(3, 0))
                0: t = 16'd0;
                1: t = 16'($urandom_range(65535, 0));
                default: t = pulse_ticks(1'($urandom_range(1, 0)));
            endcase
            send_word(t, i == len - 1, 1'b0, bpir_pkg::ST_OK);
        end
    endtask

    // hold the sender until every frame word is back, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic run_phase(input int unsigned tick, sh, lg, tol, input int n,
                             input bit quiet);
        int first;
        int sel;
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= bpir_pkg::CFG_TICK_US;
        cfg_data <= 16'(tick);
        @(negedge clk);
        cfg_idx  <= bpir_pkg::CFG_SHORT_US;
        cfg_data <= 16'(sh);
        @(negedge clk);
        cfg_idx  <= bpir_pkg::CFG_LONG_US;
        cfg_data <= 16'(lg);
        @(negedge clk);
        cfg_idx  <= bpir_pkg::CFG_TOLERANCE_US;
        cfg_data <= 16'(tol);
        @(negedge clk);
        cfg_we   <= 1'b0;
        tick_us  = tick;
        short_us = sh;
        long_us  = lg;
        tol_us   = tol;
        calm     = quiet;
        first    = word_cnt;
        while (word_cnt - first < n) begin
            sel = $urandom_range(99, 0);
            if (sel < 75)
                send_frame(23'($urandom), 1'($urandom_range(1, 0)), sel < 12);
            else
                send_noise();
            if ($urandom_range(19, 0) == 0)
                settle();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_TAB[i]) begin
            if (DIR_TAB[i].kind == ROW_FRAME)
                send_frame(DIR_TAB[i].pat, DIR_TAB[i].trim, 1'b0);
            else
                for (int r = 0; r < int'(DIR_TAB[i].reps); r++)
                    send_word(DIR_TAB[i].ticks, DIR_TAB[i].last, DIR_TAB[i].typed,
                              DIR_TAB[i].st);
        end

        run_phase(1,    250,   500,   0,     300, 1'b1);
        run_phase(1000, 1000,  2000,  400,   250, 1'b0);
        run_phase(21,   889,   1778,  300,   300, 1'b0);
        run_phase(7,    65535, 65535, 65535, 100, 1'b0);
        run_phase(3,    1,     1,     0,     100, 1'b0);
        run_phase(50,   250,   500,   50,    250, 1'b0);

        settle();
        if (bad_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
